// ----- rtl/core/hpg_pkg.sv -----
// shared types and constants for the hex pixel/grid converter
`default_nettype none
package hpg_pkg;

  localparam int PIX_W   = 24;
  localparam int IDX_W   = 16;
  localparam int SIDE_W  = 16;
  localparam int PITCH_W = 33;
  localparam int DEN_A_W = 18;

  localparam logic [16:0] SQRT3_Q16 = 17'd113512;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 16'd8192;

  localparam logic signed [IDX_W-1:0] IDX_MAX = 16'sh7fff;
  localparam logic signed [IDX_W-1:0] IDX_MIN = -16'sh8000;
  localparam logic signed [PIX_W-1:0] PIX_MAX = 24'sh7fffff;
  localparam logic signed [PIX_W-1:0] PIX_MIN = -24'sh800000;

  typedef enum logic [1:0] {
    REQ_P2G  = 2'd0,
    REQ_G2P  = 2'd1,
    REQ_SNAP = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // sideband that rides along the divider
  typedef struct packed {
    req_t                      mode;
    logic                      neg_x;
    logic                      neg_y;
    logic signed [IDX_W-1:0]   gc;
    logic signed [IDX_W-1:0]   gr;
    logic [SIDE_W-1:0]         s;
    logic [PITCH_W-1:0]        pitch;
  } hpg_tag_t;

  // handoff from pixel-to-grid to grid-to-pixel
  typedef struct packed {
    req_t                      mode;
    logic signed [IDX_W-1:0]   col;
    logic signed [IDX_W-1:0]   row;
    logic                      sat;
    logic [SIDE_W-1:0]         s;
    logic [PITCH_W-1:0]        pitch;
  } hpg_mid_t;

endpackage
`default_nettype wire

// ----- rtl/core/hex_pixel_grid_convert.sv -----
// pipeline: 23 + FRAC_BITS divider stages and 6 more registers from start to done
// throughput: one request per cycle; busy is always low
// the two divisions (by 3*side and by the row pitch) run one quotient bit per pipeline stage and set the depth
// results come on done for one cycle each; the receiver cannot stall
// reset: rst is synchronous, clears all valid bits, side_length returns to 8192
`default_nettype none
module hex_pixel_grid_convert #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [hpg_pkg::SIDE_W-1:0]   cfg_wdata,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   req_type,
  input  wire logic signed [hpg_pkg::PIX_W-1:0] pixel_x,
  input  wire logic signed [hpg_pkg::PIX_W-1:0] pixel_y,
  input  wire logic signed [hpg_pkg::IDX_W-1:0] grid_col,
  input  wire logic signed [hpg_pkg::IDX_W-1:0] grid_row,
  output logic                              done,
  output logic signed [hpg_pkg::IDX_W-1:0]  out_col,
  output logic signed [hpg_pkg::IDX_W-1:0]  out_row,
  output logic signed [hpg_pkg::PIX_W-1:0]  out_x,
  output logic signed [hpg_pkg::PIX_W-1:0]  out_y,
  output logic                              saturated
);

  logic [hpg_pkg::SIDE_W-1:0] side_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= hpg_pkg::SIDE_RESET;
    end else if (cfg_we) begin
      side_length <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  logic              mid_valid;
  hpg_pkg::hpg_mid_t mid;

  hpg_p2g #(
    .FRAC_BITS (FRAC_BITS)
  ) u_p2g (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start),
    .req_type    (req_type),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .grid_col    (grid_col),
    .grid_row    (grid_row),
    .side_length (side_length),
    .out_valid   (mid_valid),
    .out_mid     (mid)
  );

  hpg_g2p u_g2p (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_mid    (mid),
    .done      (done),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_x     (out_x),
    .out_y     (out_y),
    .saturated (saturated)
  );

endmodule
`default_nettype wire

// ----- rtl/core/hpg_div.sv -----
// pipelined restoring divider, two quotients in lockstep, one bit per stage
`default_nettype none
module hpg_div #(
  parameter int QW = 39,
  parameter int NA = 18,
  parameter int NB = 33,
  parameter int TW = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [TW-1:0]       in_tag,
  input  wire logic [NA+QW-1:0]    num_a,
  input  wire logic [NA-1:0]       den_a,
  input  wire logic [NB+QW-1:0]    num_b,
  input  wire logic [NB-1:0]       den_b,
  output logic                     out_valid,
  output logic [TW-1:0]            out_tag,
  output logic [QW-1:0]            quo_a,
  output logic                     rnz_a,
  output logic [QW-1:0]            quo_b,
  output logic                     rnz_b
);

  localparam int RA = NA + QW;
  localparam int RB = NB + QW;

  logic          vld [0:QW-1];
  logic [TW-1:0] tg  [0:QW-1];
  logic [RA-1:0] ra  [0:QW-1];
  logic [NA-1:0] da  [0:QW-1];
  logic [QW-1:0] qa  [0:QW-1];
  logic [RB-1:0] rb  [0:QW-1];
  logic [NB-1:0] db  [0:QW-1];
  logic [QW-1:0] qb  [0:QW-1];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int SH = QW - 1 - j;
    logic          pv;
    logic [TW-1:0] pt;
    logic [RA-1:0] pra, sa;
    logic [NA-1:0] pda;
    logic [QW-1:0] pqa;
    logic [RB-1:0] prb, sb;
    logic [NB-1:0] pdb;
    logic [QW-1:0] pqb;
    logic          ge_a, ge_b;

    if (j == 0) begin : g_first
      assign pv  = in_valid;
      assign pt  = in_tag;
      assign pra = num_a;
      assign pda = den_a;
      assign pqa = '0;
      assign prb = num_b;
      assign pdb = den_b;
      assign pqb = '0;
    end else begin : g_next
      assign pv  = vld[j-1];
      assign pt  = tg[j-1];
      assign pra = ra[j-1];
      assign pda = da[j-1];
      assign pqa = qa[j-1];
      assign prb = rb[j-1];
      assign pdb = db[j-1];
      assign pqb = qb[j-1];
    end

    // divisor aligned to this quotient bit
    assign sa   = RA'(pda) << SH;
    assign sb   = RB'(pdb) << SH;
    assign ge_a = pra >= sa;
    assign ge_b = prb >= sb;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      tg[j] <= pt;
      da[j] <= pda;
      db[j] <= pdb;
      ra[j] <= ge_a ? pra - sa : pra;
      rb[j] <= ge_b ? prb - sb : prb;
      qa[j] <= pqa | (ge_a ? (QW'(1) << SH) : '0);
      qb[j] <= pqb | (ge_b ? (QW'(1) << SH) : '0);
    end
  end

  assign out_valid = vld[QW-1];
  assign out_tag   = tg[QW-1];
  assign quo_a     = qa[QW-1];
  assign quo_b     = qb[QW-1];
  assign rnz_a     = |ra[QW-1];
  assign rnz_b     = |rb[QW-1];

endmodule
`default_nettype wire

// ----- rtl/core/hpg_p2g.sv -----
// pixel to grid: scaling, divisions by 3*side and by the row pitch, odd column shift, corner triangle fixup, clamping
`default_nettype none
module hpg_p2g #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [1:0]                   req_type,
  input  wire logic signed [hpg_pkg::PIX_W-1:0] pixel_x,
  input  wire logic signed [hpg_pkg::PIX_W-1:0] pixel_y,
  input  wire logic signed [hpg_pkg::IDX_W-1:0] grid_col,
  input  wire logic signed [hpg_pkg::IDX_W-1:0] grid_row,
  input  wire logic [hpg_pkg::SIDE_W-1:0]   side_length,
  output logic                              out_valid,
  output hpg_pkg::hpg_mid_t                 out_mid
);

  localparam int QW = 23 + FRAC_BITS;
  localparam int NA = hpg_pkg::DEN_A_W;
  localparam int NB = hpg_pkg::PITCH_W;
  localparam int RA = NA + QW;
  localparam int RB = NB + QW;
  localparam int UW = QW + 2;
  localparam int CW = UW - FRAC_BITS + 1;
  localparam int TW = $bits(hpg_pkg::hpg_tag_t);
  localparam int FW = FRAC_BITS + 3;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
  localparam logic signed [UW:0] HALF = (UW+1)'(1) << (FRAC_BITS - 1);

  // front stage: magnitudes, divisors, row pitch
  logic [hpg_pkg::SIDE_W-1:0]  s_val;
  logic [hpg_pkg::PIX_W-1:0]   ax, ay;
  logic [hpg_pkg::PITCH_W-1:0] pitch;

  assign s_val = (side_length == '0) ? hpg_pkg::SIDE_W'(1) : side_length;
  assign ax    = pixel_x[hpg_pkg::PIX_W-1] ? ~pixel_x + 1'b1 : pixel_x;
  assign ay    = pixel_y[hpg_pkg::PIX_W-1] ? ~pixel_y + 1'b1 : pixel_y;
  assign pitch = hpg_pkg::PITCH_W'(s_val) * hpg_pkg::PITCH_W'(hpg_pkg::SQRT3_Q16);

  logic              f_valid;
  hpg_pkg::hpg_tag_t f_tag;
  logic [RA-1:0]     f_num_a;
  logic [NA-1:0]     f_den_a;
  logic [RB-1:0]     f_num_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    f_tag.mode  <= hpg_pkg::req_t'(req_type);
    f_tag.neg_x <= pixel_x[hpg_pkg::PIX_W-1];
    f_tag.neg_y <= pixel_y[hpg_pkg::PIX_W-1];
    f_tag.gc    <= grid_col;
    f_tag.gr    <= grid_row;
    f_tag.s     <= s_val;
    f_tag.pitch <= pitch;
    f_num_a     <= RA'(ax) << (FRAC_BITS + 1);
    f_num_b     <= RB'(ay) << (FRAC_BITS + 16);
    f_den_a     <= NA'({s_val, 1'b0}) + NA'(s_val);
  end

  logic              d_valid;
  logic [TW-1:0]     d_tag_bits;
  hpg_pkg::hpg_tag_t d_tag;
  logic [QW-1:0]     quo_a, quo_b;
  logic              rnz_a, rnz_b;

  hpg_div #(
    .QW (QW),
    .NA (NA),
    .NB (NB),
    .TW (TW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_tag    (f_tag),
    .num_a     (f_num_a),
    .den_a     (f_den_a),
    .num_b     (f_num_b),
    .den_b     (f_tag.pitch),
    .out_valid (d_valid),
    .out_tag   (d_tag_bits),
    .quo_a     (quo_a),
    .rnz_a     (rnz_a),
    .quo_b     (quo_b),
    .rnz_b     (rnz_b)
  );

  assign d_tag = hpg_pkg::hpg_tag_t'(d_tag_bits);

  // floor quotients for negative dividends
  logic signed [UW-1:0] u_n, v_n;
  assign u_n = d_tag.neg_x ? -(UW'(quo_a) + UW'(rnz_a)) : UW'(quo_a);
  assign v_n = d_tag.neg_y ? -(UW'(quo_b) + UW'(rnz_b)) : UW'(quo_b);

  logic                 q1_valid;
  hpg_pkg::hpg_tag_t    q1_tag;
  logic signed [UW-1:0] u, v;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid <= 1'b0;
    end else begin
      q1_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    q1_tag <= d_tag;
    u      <= u_n;
    v      <= v_n;
  end

  // cell rectangle and triangle tests
  logic signed [CW-1:0] c, k, r0, c_adj, r_adj;
  logic signed [UW:0]   vh;
  logic                 odd, t_top, t_bot;
  logic [FW-1:0]        tx, ty, sum_a, lhs_b, rhs_b;

  assign c     = CW'(u >>> FRAC_BITS);
  assign vh    = (UW+1)'(v) + HALF;
  assign k     = CW'(vh >>> FRAC_BITS);
  assign odd   = c[0];
  assign r0    = odd ? k - CW'(1) : CW'(v >>> FRAC_BITS);
  assign tx    = FW'(u[FRAC_BITS-1:0]);
  assign ty    = odd ? FW'(vh[FRAC_BITS-1:0]) : FW'(v[FRAC_BITS-1:0]);
  assign sum_a = (tx << 1) + tx + (ty << 1);
  assign lhs_b = (tx << 1) + tx + ONE;
  assign rhs_b = ty << 1;
  assign t_top = sum_a < ONE;
  assign t_bot = lhs_b <= rhs_b;

  always_comb begin
    c_adj = c;
    r_adj = r0;
    if (t_top) begin
      c_adj = c - CW'(1);
      r_adj = odd ? r0 : r0 - CW'(1);
    end else if (t_bot) begin
      c_adj = c - CW'(1);
      r_adj = odd ? r0 + CW'(1) : r0;
    end
  end

  logic                 q2_valid;
  hpg_pkg::hpg_tag_t    q2_tag;
  logic signed [CW-1:0] c2, r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_valid <= 1'b0;
    end else begin
      q2_valid <= q1_valid;
    end
  end

  always_ff @(posedge clk) begin
    q2_tag <= q1_tag;
    c2     <= c_adj;
    r2     <= r_adj;
  end

  // clamp to index range; grid-to-pixel requests take the given cell
  logic                             c_hi, c_lo, r_hi, r_lo;
  logic signed [hpg_pkg::IDX_W-1:0] c_cl, r_cl;
  hpg_pkg::hpg_mid_t                mid_next;

  assign c_hi = c2 > CW'(hpg_pkg::IDX_MAX);
  assign c_lo = c2 < CW'(hpg_pkg::IDX_MIN);
  assign r_hi = r2 > CW'(hpg_pkg::IDX_MAX);
  assign r_lo = r2 < CW'(hpg_pkg::IDX_MIN);
  assign c_cl = c_hi ? hpg_pkg::IDX_MAX : c_lo ? hpg_pkg::IDX_MIN : hpg_pkg::IDX_W'(c2);
  assign r_cl = r_hi ? hpg_pkg::IDX_MAX : r_lo ? hpg_pkg::IDX_MIN : hpg_pkg::IDX_W'(r2);

  always_comb begin
    mid_next.mode  = q2_tag.mode;
    mid_next.s     = q2_tag.s;
    mid_next.pitch = q2_tag.pitch;
    if (q2_tag.mode == hpg_pkg::REQ_G2P) begin
      mid_next.col = q2_tag.gc;
      mid_next.row = q2_tag.gr;
      mid_next.sat = 1'b0;
    end else begin
      mid_next.col = c_cl;
      mid_next.row = r_cl;
      mid_next.sat = c_hi | c_lo | r_hi | r_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= q2_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_mid <= mid_next;
  end

endmodule
`default_nettype wire

// ----- rtl/core/hpg_g2p.sv -----
// grid to pixel: hex centre from column and row, saturation, result select
`default_nettype none
module hpg_g2p (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire hpg_pkg::hpg_mid_t            in_mid,
  output logic                              done,
  output logic signed [hpg_pkg::IDX_W-1:0]  out_col,
  output logic signed [hpg_pkg::IDX_W-1:0]  out_row,
  output logic signed [hpg_pkg::PIX_W-1:0]  out_x,
  output logic signed [hpg_pkg::PIX_W-1:0]  out_y,
  output logic                              saturated
);

  localparam int XPW = 35;
  localparam int YPW = 52;

  logic signed [17:0]    col_e, col3, m;
  logic signed [16:0]    s_sg;
  logic signed [33:0]    pitch_sg;
  logic signed [XPW-1:0] xp_next;
  logic signed [YPW-1:0] yp_next;

  assign col_e    = 18'(in_mid.col);
  assign col3     = (col_e <<< 1) + col_e;
  assign s_sg     = $signed({1'b0, in_mid.s});
  assign pitch_sg = $signed({1'b0, in_mid.pitch});
  // 1 + 2*row + parity, parity of a negative column taken non-negative
  assign m        = 18'sd1 + (18'(in_mid.row) <<< 1) + $signed({17'd0, in_mid.col[0]});
  assign xp_next  = col3 * s_sg;
  assign yp_next  = pitch_sg * m;

  logic                    g_valid;
  hpg_pkg::hpg_mid_t       g_mid;
  logic signed [XPW-1:0]   xp;
  logic signed [YPW-1:0]   yp;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else begin
      g_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    g_mid <= in_mid;
    xp    <= xp_next;
    yp    <= yp_next;
  end

  logic signed [XPW+1:0] x2, xf;
  logic signed [YPW:0]   yf;
  logic                  x_hi, x_lo, y_hi, y_lo, g_sat;
  logic signed [hpg_pkg::PIX_W-1:0] x_cl, y_cl;

  assign x2   = (XPW+2)'(xp) + (XPW+2)'({g_mid.s, 1'b0}) + (XPW+2)'(1);
  assign xf   = x2 >>> 1;
  assign yf   = ((YPW+1)'(yp) + ((YPW+1)'(1) << 16)) >>> 17;
  assign x_hi = xf > (XPW+2)'(hpg_pkg::PIX_MAX);
  assign x_lo = xf < (XPW+2)'(hpg_pkg::PIX_MIN);
  assign y_hi = yf > (YPW+1)'(hpg_pkg::PIX_MAX);
  assign y_lo = yf < (YPW+1)'(hpg_pkg::PIX_MIN);
  assign x_cl = x_hi ? hpg_pkg::PIX_MAX : x_lo ? hpg_pkg::PIX_MIN : hpg_pkg::PIX_W'(xf);
  assign y_cl = y_hi ? hpg_pkg::PIX_MAX : y_lo ? hpg_pkg::PIX_MIN : hpg_pkg::PIX_W'(yf);
  assign g_sat = x_hi | x_lo | y_hi | y_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    case (g_mid.mode)
      hpg_pkg::REQ_P2G: begin
        out_col   <= g_mid.col;
        out_row   <= g_mid.row;
        out_x     <= '0;
        out_y     <= '0;
        saturated <= g_mid.sat;
      end
      hpg_pkg::REQ_G2P: begin
        out_col   <= '0;
        out_row   <= '0;
        out_x     <= x_cl;
        out_y     <= y_cl;
        saturated <= g_sat;
      end
      hpg_pkg::REQ_SNAP: begin
        out_col   <= g_mid.col;
        out_row   <= g_mid.row;
        out_x     <= x_cl;
        out_y     <= y_cl;
        saturated <= g_mid.sat | g_sat;
      end
      default: begin
        out_col   <= '0;
        out_row   <= '0;
        out_x     <= '0;
        out_y     <= '0;
        saturated <= 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- tb/sv/hex_pixel_grid_convert_chk.sv -----
// checker for the hex pixel/grid converter: predicts each beat and compares results
`timescale 1ns / 100ps
module hex_pixel_grid_convert_chk #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [hpg_pkg::SIDE_W-1:0]            cfg_wdata,
  input  wire logic                                  start,
  input  wire logic                                  busy,
  input  wire logic [1:0]                            req_type,
  input  wire logic signed [hpg_pkg::PIX_W-1:0]      pixel_x,
  input  wire logic signed [hpg_pkg::PIX_W-1:0]      pixel_y,
  input  wire logic signed [hpg_pkg::IDX_W-1:0]      grid_col,
  input  wire logic signed [hpg_pkg::IDX_W-1:0]      grid_row,
  input  wire logic                                  done,
  input  wire logic signed [hpg_pkg::IDX_W-1:0]      out_col,
  input  wire logic signed [hpg_pkg::IDX_W-1:0]      out_row,
  input  wire logic signed [hpg_pkg::PIX_W-1:0]      out_x,
  input  wire logic signed [hpg_pkg::PIX_W-1:0]      out_y,
  input  wire logic                                  saturated,
  output int                                         fail_count,
  output int                                         pending
);

  typedef struct packed {
    logic signed [hpg_pkg::IDX_W-1:0] col;
    logic signed [hpg_pkg::IDX_W-1:0] row;
    logic signed [hpg_pkg::PIX_W-1:0] x;
    logic signed [hpg_pkg::PIX_W-1:0] y;
    logic                             sat;
  } hex_res_t;

  localparam longint SQRT3 = 113512;

  hex_res_t    centre_q[$];
  logic [15:0] side_reg;

  function automatic longint fdiv(bit neg, longint mag, longint den);
    longint q;
    q = mag / den;
    if (!neg) return q;
    return -(q + ((mag % den) != 0));
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi, ref bit sat);
    if (v < lo) begin sat = 1; return lo; end
    if (v > hi) begin sat = 1; return hi; end
    return v;
  endfunction

  function automatic void locate_hex(longint px, longint py, longint s,
                                     ref longint col, ref longint row, ref bit sat);
    longint one, half, u, v, c, r, top, tx, ty, k;
    bit odd;
    one  = longint'(1) << FRAC_BITS;
    half = one >>> 1;
    u = fdiv(px < 0, (px < 0 ? -px : px) << (FRAC_BITS + 1), 3 * s);
    v = fdiv(py < 0, (py < 0 ? -py : py) << (FRAC_BITS + 16), s * SQRT3);
    c = u >>> FRAC_BITS;
    odd = c[0];
    if (odd) begin
      k = (v + half) >>> FRAC_BITS;
      top = k * one - half;
      r = k - 1;
    end else begin
      r = v >>> FRAC_BITS;
      top = r * one;
    end
    tx = u - c * one;
    ty = v - top;
    // left corner triangles belong to the previous column
    if (3 * tx + 2 * ty < one) begin
      c -= 1;
      if (!odd) r -= 1;
    end else if (3 * tx + one <= 2 * ty) begin
      c -= 1;
      if (odd) r += 1;
    end
    col = clampv(c, -32768, 32767, sat);
    row = clampv(r, -32768, 32767, sat);
  endfunction

  function automatic void hex_centre(longint col, longint row, longint s,
                                     ref longint x, ref longint y, ref bit sat);
    longint pitch;
    pitch = s * SQRT3;
    x = clampv((2 * s + 3 * col * s + 1) >>> 1, -8388608, 8388607, sat);
    y = clampv((pitch * (1 + 2 * row + (col & 1)) + (longint'(1) << 16)) >>> 17,
               -8388608, 8388607, sat);
  endfunction

  function automatic hex_res_t convert(hpg_pkg::req_t mode, longint px, longint py,
                                       longint gc, longint gr, longint s);
    hex_res_t res;
    longint col, row, x, y;
    bit sat;
    col = 0; row = 0; x = 0; y = 0; sat = 0;
    case (mode)
      hpg_pkg::REQ_P2G: locate_hex(px, py, s, col, row, sat);
      hpg_pkg::REQ_G2P: hex_centre(gc, gr, s, x, y, sat);
      hpg_pkg::REQ_SNAP: begin
        locate_hex(px, py, s, col, row, sat);
        hex_centre(col, row, s, x, y, sat);
      end
      default: ;
    endcase
    res.col = col[15:0];
    res.row = row[15:0];
    res.x   = x[23:0];
    res.y   = y[23:0];
    res.sat = sat;
    return res;
  endfunction

  assign pending = centre_q.size();

  always @(posedge clk) begin
    hex_res_t want;
    if (rst) begin
      side_reg   <= hpg_pkg::SIDE_RESET;
      fail_count <= 0;
      centre_q.delete();
    end else begin
      if (cfg_we) side_reg <= cfg_wdata;
      if (start && !busy)
        centre_q.push_back(convert(hpg_pkg::req_t'(req_type), pixel_x, pixel_y,
                                   grid_col, grid_row, side_reg == 0 ? 1 : side_reg));
      if (done) begin
        if (centre_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = centre_q.pop_front();
          if (out_col !== want.col || out_row !== want.row || out_x !== want.x ||
              out_y !== want.y || saturated !== want.sat) begin
            if (out_col !== want.col) $error("out_col exp %0d got %0d", want.col, out_col);
            if (out_row !== want.row) $error("out_row exp %0d got %0d", want.row, out_row);
            if (out_x !== want.x) $error("out_x exp %0d got %0d", want.x, out_x);
            if (out_y !== want.y) $error("out_y exp %0d got %0d", want.y, out_y);
            if (saturated !== want.sat)
              $error("saturated exp %0d got %0d", want.sat, saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/hex_pixel_grid_convert_tb.sv -----
// testbench top for the hex pixel/grid converter: stimulus, config phases and verdict
`timescale 1ns / 100ps
module hex_pixel_grid_convert_tb;

  localparam int FRAC_BITS = 16;
  localparam int SETTLE    = FRAC_BITS + 40;

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [hpg_pkg::SIDE_W-1:0]       cfg_wdata;
  logic                             start;
  logic                             busy;
  logic [1:0]                       req_type;
  logic signed [hpg_pkg::PIX_W-1:0] pixel_x;
  logic signed [hpg_pkg::PIX_W-1:0] pixel_y;
  logic signed [hpg_pkg::IDX_W-1:0] grid_col;
  logic signed [hpg_pkg::IDX_W-1:0] grid_row;
  logic                             done;
  logic signed [hpg_pkg::IDX_W-1:0] out_col;
  logic signed [hpg_pkg::IDX_W-1:0] out_row;
  logic signed [hpg_pkg::PIX_W-1:0] out_x;
  logic signed [hpg_pkg::PIX_W-1:0] out_y;
  logic                             saturated;
  int                               fail_count;
  int                               pending;
  bit                               gaps_on;

  hex_pixel_grid_convert #(.FRAC_BITS(FRAC_BITS)) u_dut (.*);
  hex_pixel_grid_convert_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12ns * 400000);
    $display("FAIL");
    $finish;
  end

  task automatic send(hpg_pkg::req_t mode, logic [23:0] px, logic [23:0] py,
                      logic [15:0] gc, logic [15:0] gr);
    // with gaps on, each cycle idles with a chance of about one in five
    while (gaps_on && $urandom_range(99) < 19) begin
      start <= 0;
      @(posedge clk);
    end
    req_type <= mode;
    pixel_x  <= px;
    pixel_y  <= py;
    grid_col <= gc;
    grid_row <= gr;
    start    <= 1;
    do @(posedge clk); while (busy);
  endtask

  // drain the pipe before touching side_length
  task automatic set_side(logic [15:0] val);
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_beat();
    hpg_pkg::req_t mode;
    logic [23:0] px, py;
    logic [15:0] gc, gr;
    mode = hpg_pkg::req_t'($urandom_range(99) < 5 ? 3 : $urandom_range(2));
    px = $urandom;
    py = $urandom;
    gc = $urandom;
    gr = $urandom;
    // mostly near the origin so the hex tests see real cells
    if ($urandom_range(3) != 0) begin
      px = 24'($signed($urandom_range(0, 65535)) - 32768);
      py = 24'($signed($urandom_range(0, 65535)) - 32768);
      gc = 16'($signed($urandom_range(0, 63)) - 32);
      gr = 16'($signed($urandom_range(0, 63)) - 32);
    end
    send(mode, px, py, gc, gr);
  endtask

  initial begin
    logic [15:0] sides[6];
    sides = '{16'd8192, 16'd0, 16'd256, 16'd65535, 16'd1, 16'd777};
    rst = 1; cfg_we = 0; cfg_wdata = 0; start = 0; req_type = hpg_pkg::REQ_P2G;
    pixel_x = 0; pixel_y = 0; grid_col = 0; grid_row = 0; gaps_on = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // extremes, every mode, parity of negative columns, unused code
    send(hpg_pkg::REQ_P2G, 24'h000000, 24'h000000, 0, 0);
    send(hpg_pkg::REQ_P2G, 24'h7fffff, 24'h7fffff, 0, 0);
    send(hpg_pkg::REQ_P2G, 24'h800000, 24'h800000, 0, 0);
    send(hpg_pkg::REQ_P2G, 24'h7fffff, 24'h800000, 0, 0);
    send(hpg_pkg::REQ_P2G, 24'hffffff, 24'hffffff, 0, 0);
    send(hpg_pkg::REQ_P2G, 24'd100, 24'd50, 0, 0);
    send(hpg_pkg::REQ_P2G, 24'hffe000, 24'hffc000, 0, 0);
    send(hpg_pkg::REQ_G2P, 0, 0, 16'h7fff, 16'h7fff);
    send(hpg_pkg::REQ_G2P, 0, 0, 16'h8000, 16'h8000);
    send(hpg_pkg::REQ_G2P, 0, 0, 16'hffff, 16'hffff);
    send(hpg_pkg::REQ_G2P, 0, 0, 16'd1, 16'hfffe);
    send(hpg_pkg::REQ_G2P, 0, 0, 16'hffff, 16'h0000);
    send(hpg_pkg::REQ_SNAP, 24'h7fffff, 24'h7fffff, 0, 0);
    send(hpg_pkg::REQ_SNAP, 24'h800000, 24'h800000, 0, 0);
    send(hpg_pkg::REQ_SNAP, 24'hfff000, 24'h003000, 0, 0);
    send(hpg_pkg::REQ_NONE, 24'h7fffff, 24'h800000, 16'h7fff, 16'h8000);
    set_side(16'd0);
    send(hpg_pkg::REQ_P2G, 24'h7fffff, 24'h800000, 0, 0);
    send(hpg_pkg::REQ_SNAP, 24'h800000, 24'h7fffff, 0, 0);
    send(hpg_pkg::REQ_G2P, 0, 0, 16'h7fff, 16'h8000);

    for (int p = 0; p < 6; p++) begin
      set_side(p == 5 ? 16'($urandom_range(256, 65535)) : sides[p]);
      gaps_on = (p != 2);
      for (int i = 0; i < 190; i++) random_beat();
    end
    set_side(16'hffff);

    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
